FILE: hdl/isotp_pkg.sv
`default_nettype none
package isotp_pkg;

   // buffer geometry
   localparam int BUFFER_BYTES = 4096;
   localparam int ADDR_W       = 12;
   localparam int LANES        = 8;
   localparam int LANE_BITS    = $clog2(LANES);
   localparam int LANE_ROWS    = (1 << ADDR_W) / LANES;
   localparam int ROW_W        = ADDR_W - LANE_BITS;
   localparam int FRAME_BYTES  = 8;

   // protocol limits
   localparam int SF_MAX  = 7;
   localparam int FF_DATA = 6;
   localparam int CF_DATA = 7;

   // commands
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // frame kinds (high nibble of byte 0)
   localparam logic [3:0] KIND_SINGLE = 4'h0;
   localparam logic [3:0] KIND_FIRST  = 4'h1;
   localparam logic [3:0] KIND_CONSEC = 4'h2;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_SINGLE  = 3'd1,
      ST_BAD_FIRST   = 3'd2,
      ST_OVERSIZE    = 3'd3,
      ST_UNEXPECTED  = 3'd4,
      ST_UNSUPPORTED = 3'd5
   } status_type;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   // buffer write order shared by all lanes
   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    base;
      logic [LANE_BITS-1:0] count;
      logic                 src_off;   // first payload byte is byte1 (0) or byte2 (1)
   } wr_cmd_type;

   typedef struct packed {
      status_type        status;
      logic [3:0]        kind;
      logic              complete;
      logic [ADDR_W-1:0] received;
      logic [ADDR_W-1:0] total;
      logic              fc_sent;
   } result_type;

   typedef struct packed {
      result_type           res;
      logic                 is_read;
      logic                 rd_ok;
      logic [LANE_BITS-1:0] lane;
   } stage_type;

endpackage
`default_nettype wire

FILE: hdl/isotp_lane.sv
`default_nettype none
module isotp_lane
   import isotp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [LANE_BITS-1:0] lane_id,
   input  wire logic                 accept,
   input  wire wr_cmd_type           wr,
   input  wire frame_type            frame,
   input  wire logic                 rd_en,
   input  wire logic [ROW_W-1:0]     rd_row,
   output logic [7:0]                rd_data
);

   logic [7:0]           bank_ff [LANE_ROWS];
   logic [7:0]           rd_data_ff;
   logic [LANE_BITS-1:0] offs;
   logic [LANE_BITS-1:0] wsel;
   logic [ADDR_W-1:0]    waddr;
   logic                 we;

   // byte position within this frame's run that lands in this bank
   assign offs  = lane_id - wr.base[LANE_BITS-1:0];
   assign wsel  = LANE_BITS'(1) + offs + LANE_BITS'(wr.src_off);
   assign waddr = wr.base + ADDR_W'(offs);
   assign we    = accept && wr.en && (offs < wr.count);

   always_ff @(posedge clock) begin
      if (we) begin
         bank_ff[waddr[ADDR_W-1:LANE_BITS]] <= frame[wsel];
      end
      if (accept && rd_en) begin
         rd_data_ff <= bank_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/isotp_ctrl.sv
`default_nettype none
module isotp_ctrl
   import isotp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      accept,
   input  wire logic      command,
   input  wire frame_type frame,
   output result_type     res,
   output wr_cmd_type     wr
);

   logic [ADDR_W-1:0]    rc_ff, rc_in;
   logic [ADDR_W-1:0]    al_ff, al_in;
   logic                 cf_ff, cf_in;
   status_type           status;
   logic [3:0]           kind;
   logic                 fc;
   logic [3:0]           sf_len;
   logic [ADDR_W:0]      ff_len;
   logic [ADDR_W-1:0]    remaining;
   logic [LANE_BITS-1:0] chunk;
   logic [ADDR_W-1:0]    cf_rc;

   assign sf_len    = frame[0][3:0];
   assign ff_len    = {1'b0, frame[0][3:0], frame[1]};
   assign remaining = (al_ff > rc_ff) ? (al_ff - rc_ff) : '0;
   assign chunk     = (remaining > ADDR_W'(CF_DATA)) ? LANE_BITS'(CF_DATA)
                                                     : remaining[LANE_BITS-1:0];
   assign cf_rc     = rc_ff + ADDR_W'(chunk);

   always_comb begin
      status = ST_OK;
      kind   = (command == CMD_FRAME) ? frame[0][7:4] : 4'h0;
      fc     = 1'b0;
      rc_in  = rc_ff;
      al_in  = al_ff;
      cf_in  = cf_ff;
      wr     = '0;
      if (command == CMD_FRAME) begin
         unique case (kind)
            KIND_SINGLE: begin
               if (sf_len > 4'(SF_MAX)) begin
                  status = ST_BAD_SINGLE;
               end else begin
                  wr.en    = 1'b1;
                  wr.count = sf_len[LANE_BITS-1:0];
                  rc_in    = ADDR_W'(sf_len);
                  al_in    = ADDR_W'(sf_len);
                  cf_in    = 1'b1;
               end
            end
            KIND_FIRST: begin
               if (ff_len > (ADDR_W+1)'(BUFFER_BYTES)) begin
                  status = ST_OVERSIZE;
               end else if (ff_len < (ADDR_W+1)'(FF_DATA + 1)) begin
                  status = ST_BAD_FIRST;
               end else begin
                  wr.en      = 1'b1;
                  wr.count   = LANE_BITS'(FF_DATA);
                  wr.src_off = 1'b1;
                  rc_in      = ADDR_W'(FF_DATA);
                  al_in      = ff_len[ADDR_W-1:0];
                  cf_in      = 1'b0;
                  fc         = 1'b1;
               end
            end
            KIND_CONSEC: begin
               if (al_ff == '0 || cf_ff) begin
                  status = ST_UNEXPECTED;
               end else begin
                  wr.en    = 1'b1;
                  wr.base  = rc_ff;
                  wr.count = chunk;
                  rc_in    = cf_rc;
                  cf_in    = (cf_rc >= al_ff);
               end
            end
            default: begin
               status = ST_UNSUPPORTED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff <= '0;
         al_ff <= '0;
         cf_ff <= 1'b0;
      end else if (accept) begin
         rc_ff <= rc_in;
         al_ff <= al_in;
         cf_ff <= cf_in;
      end
   end

   assign res.status   = status;
   assign res.kind     = kind;
   assign res.complete = cf_in;
   assign res.received = rc_in;
   assign res.total    = al_in;
   assign res.fc_sent  = fc;

`ifndef SYNTH
   a_complete_full: assert property (@(posedge clock) disable iff (reset)
      cf_ff |-> (rc_ff == al_ff))
      else $error("complete flag set with bytes outstanding");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rc_ff <= al_ff)
      else $error("received count beyond announced length");

   a_active_min: assert property (@(posedge clock) disable iff (reset)
      (al_ff != '0 && !cf_ff) |-> (rc_ff >= ADDR_W'(FF_DATA)))
      else $error("active reception without first frame payload");
`endif

endmodule
`default_nettype wire

FILE: hdl/isotp_merge.sv
`default_nettype none
module isotp_merge
   import isotp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       s1_valid,
   input  wire stage_type                  s1,
   input  wire logic [LANES-1:0][7:0]      lane_rd,
   output logic                            s1_take,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [39:0]                     rsp_tdata,
   output logic [3:0]                      rsp_tuser
);

   logic       out_valid_ff;
   result_type out_res_ff;
   logic [7:0] out_rdata_ff;
   logic [7:0] rdata_sel;

   assign s1_take   = s1_valid && (!out_valid_ff || rsp_tready);
   assign rdata_sel = (s1.is_read && s1.rd_ok) ? lane_rd[s1.lane] : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         out_res_ff   <= s1.res;
         out_rdata_ff <= rdata_sel;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_rdata_ff, out_res_ff.fc_sent, out_res_ff.total,
                        out_res_ff.received, out_res_ff.complete, out_res_ff.status};
   assign rsp_tuser  = out_res_ff.kind;

endmodule
`default_nettype wire

FILE: hdl/isotp_frame_reassembler_unit.sv
// Pipeline: two register stages, the middle stage and the output register; rsp_tvalid
// rises when the output register takes the item, which a stall at the output can delay.
// Throughput: one item per cycle without stalls; eight banks take up to seven bytes at once.
// Backpressure: a held result and one item in flight may wait; req_tready follows rsp_tready.
// Reset: clears the counts, complete flag and valid bits, and holds req_tready low. The
// payload buffer keeps its contents and is not swept, so no clearing pass is needed.
`default_nettype none
module isotp_frame_reassembler_unit
   import isotp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // byte0..byte7 [63:0], read_address [75:64]
   input  wire logic        req_tuser,   // command
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // status [2:0], msg_complete [3],
                                         // rx_bytes [15:4], msg_length [27:16],
                                         // flow_control_sent [28], read_data [36:29]
   output logic [3:0]       rsp_tuser    // frame_kind
);

   frame_type             frame;
   logic [ADDR_W-1:0]     read_address;
   logic                  accept;
   logic                  s1_take;
   logic                  s1_valid_ff;
   stage_type             s1_ff;
   result_type            res;
   wr_cmd_type            wr;
   logic                  rd_en;
   logic [LANES-1:0][7:0] lane_rd;

   // unpack the item
   always_comb begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
         frame[k] = req_tdata[8*k +: 8];
      end
   end
   assign read_address = req_tdata[8*FRAME_BYTES +: ADDR_W];

   // the middle stage may refill in the cycle it hands over; nothing is taken in reset,
   // so the buffer cannot be written then
   assign req_tready = !reset && (!s1_valid_ff || s1_take);
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = (req_tuser == CMD_READ);

   // classification and reception counters
   isotp_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .command (req_tuser),
      .frame   (frame),
      .res     (res),
      .wr      (wr)
   );

   // one bank per lane, interleaved on the low address bits: a run of up to
   // seven consecutive bytes always falls in distinct banks
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      isotp_lane u_lane (
         .clock   (clock),
         .lane_id (LANE_BITS'(g)),
         .accept  (accept),
         .wr      (wr),
         .frame   (frame),
         .rd_en   (rd_en),
         .rd_row  (read_address[ADDR_W-1:LANE_BITS]),
         .rd_data (lane_rd[g])
      );
   end

   // stage between accept and the output register; bank reads land alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_take) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.res     <= res;
         s1_ff.is_read <= rd_en;
         s1_ff.rd_ok   <= ({1'b0, read_address} < (ADDR_W+1)'(BUFFER_BYTES));
         s1_ff.lane    <= read_address[LANE_BITS-1:0];
      end
   end

   // picks the bank byte and holds the result for the consumer
   isotp_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid_ff),
      .s1         (s1_ff),
      .lane_rd    (lane_rd),
      .s1_take    (s1_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
